// File: src/apsp_pkg.sv
package apsp_pkg;

  // graph size and field widths
  localparam int MAX_NODES  = 128;
  localparam int COST_BITS  = 10;
  localparam int FIELD_BITS = 8;
  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int ADDR_BITS  = 2 * NODE_BITS;
  localparam int RAM_DEPTH  = 2 ** ADDR_BITS;
  localparam int DIST_BITS  = 17;
  localparam int ENTRY_BITS = DIST_BITS + 1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef logic [NODE_BITS-1:0]  node_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_IK_RD,
    ST_IK_WAIT,
    ST_ROW,
    ST_FIN_RD,
    ST_FIN_WAIT
  } apsp_state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic edge_wr;
    logic edge_rev;
    logic relax_start;
    logic ik_rd;
    logic ik_load;
    logic row_rd;
    logic step_ik;
    logic fin_rd;
    logic fin_load;
  } apsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic edge_last;
    logic ik_valid;
    logic j_last;
    logic i_last;
    logic k_last;
    logic out_busy;
  } apsp_sts_t;

endpackage

// File: src/apsp_edge_if.sv
interface apsp_edge_if
  import apsp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] from_node;
  logic [FIELD_BITS-1:0] to_node;
  logic [COST_BITS-1:0]  edge_cost;
  logic                  last_edge;

  modport source (output valid, from_node, to_node, edge_cost, last_edge, input ready);
  modport sink   (input valid, from_node, to_node, edge_cost, last_edge, output ready);
endinterface

// File: src/apsp_result_if.sv
interface apsp_result_if
  import apsp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic                 reachable;

  modport source (output valid, distance, reachable, input ready);
  modport sink   (input valid, distance, reachable, output ready);
endinterface

// File: src/apsp_ram.sv
module apsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/apsp_datapath.sv
module apsp_datapath
  import apsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  apsp_cmd_t             cmd,
  output apsp_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [FIELD_BITS-1:0] cfg_data,
  input  logic [FIELD_BITS-1:0] from_node,
  input  logic [FIELD_BITS-1:0] to_node,
  input  logic [COST_BITS-1:0]  edge_cost,
  input  logic                  last_edge,
  output logic [DIST_BITS-1:0]  distance,
  output logic                  reachable,
  output logic                  out_valid,
  input  logic                  out_ready
);

  logic [FIELD_BITS-1:0] node_count;
  addr_t                 clr_cnt;
  addr_t                 rev_addr;
  logic                  rev_ok;
  logic [DIST_BITS-1:0]  rev_cost;
  logic                  last_q;
  node_t                 n_m1;
  node_t                 k;
  node_t                 i;
  node_t                 j;
  entry_t                ik;
  logic                  pend;
  node_t                 pend_i;
  node_t                 pend_j;

  logic                  from_ok;
  logic                  to_ok;
  logic                  edge_ok;
  node_t                 from_idx;
  node_t                 to_idx;
  logic [DIST_BITS-1:0]  cost_sat;
  logic [DIST_BITS:0]    sum;
  logic [DIST_BITS-1:0]  sum_sat;
  logic                  better;
  logic                  we;
  addr_t                 waddr;
  entry_t                wdata;
  addr_t                 raddr_a;
  addr_t                 raddr_b;
  entry_t                rdata_a;
  entry_t                rdata_b;

  // distance matrix
  apsp_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= FIELD_BITS'(1);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  // edge decode
  always_comb begin
    from_ok  = (from_node != '0) && (32'(from_node) <= MAX_NODES);
    to_ok    = (to_node != '0) && (32'(to_node) <= MAX_NODES);
    edge_ok  = from_ok && to_ok && (from_node != to_node);
    from_idx = NODE_BITS'(from_node - FIELD_BITS'(1));
    to_idx   = NODE_BITS'(to_node - FIELD_BITS'(1));
    cost_sat = (32'(edge_cost) > 32'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(edge_cost);
  end

  // reverse direction of the edge, written in the cycle after the forward write
  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      rev_addr <= {to_idx, from_idx};
      rev_ok   <= edge_ok;
      rev_cost <= cost_sat;
      last_q   <= last_edge;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + ADDR_BITS'(1);
    end
  end

  // relaxation loop counters
  always_ff @(posedge clk) begin
    if (cmd.relax_start) begin
      if (node_count == '0) begin
        n_m1 <= '0;
      end else if (32'(node_count) > MAX_NODES) begin
        n_m1 <= NODE_BITS'(MAX_NODES - 1);
      end else begin
        n_m1 <= NODE_BITS'(node_count - FIELD_BITS'(1));
      end
      k <= '0;
      i <= '0;
    end else if (cmd.step_ik) begin
      if (i == n_m1) begin
        i <= '0;
        k <= k + NODE_BITS'(1);
      end else begin
        i <= i + NODE_BITS'(1);
      end
    end
    if (cmd.ik_rd) begin
      j <= '0;
    end else if (cmd.row_rd) begin
      j <= j + NODE_BITS'(1);
    end
    if (cmd.ik_load) begin
      ik <= rdata_a;
    end
  end

  // read data for a row element arrives in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.row_rd;
    end
    pend_i <= i;
    pend_j <= j;
  end

  // relax step: d[i][j] = min(d[i][j], d[i][k] + d[k][j])
  always_comb begin
    sum     = {1'b0, ik[DIST_BITS-1:0]} + {1'b0, rdata_a[DIST_BITS-1:0]};
    sum_sat = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    better  = pend && rdata_a[DIST_BITS] &&
              (!rdata_b[DIST_BITS] || (sum_sat < rdata_b[DIST_BITS-1:0]));
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = (clr_cnt[ADDR_BITS-1:NODE_BITS] == clr_cnt[NODE_BITS-1:0]) ?
              {1'b1, DIST_BITS'(0)} : '0;
    end else if (cmd.edge_wr) begin
      we    = edge_ok;
      waddr = {from_idx, to_idx};
      wdata = {1'b1, cost_sat};
    end else if (cmd.edge_rev) begin
      we    = rev_ok;
      waddr = rev_addr;
      wdata = {1'b1, rev_cost};
    end else if (better) begin
      we    = 1'b1;
      waddr = {pend_i, pend_j};
      wdata = {1'b1, sum_sat};
    end
  end

  // read address select
  always_comb begin
    if (cmd.ik_rd) begin
      raddr_a = {i, k};
    end else if (cmd.fin_rd) begin
      raddr_a = {NODE_BITS'(0), n_m1};
    end else begin
      raddr_a = {k, j};
    end
    raddr_b = {i, j};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.fin_load) begin
      distance  <= rdata_a[DIST_BITS] ? rdata_a[DIST_BITS-1:0] : '0;
      reachable <= rdata_a[DIST_BITS];
    end
  end

  // status to controller
  always_comb begin
    sts.clr_last  = (clr_cnt == '1);
    sts.edge_last = last_q;
    sts.ik_valid  = rdata_a[DIST_BITS];
    sts.j_last    = (j == n_m1);
    sts.i_last    = (i == n_m1);
    sts.k_last    = (k == n_m1);
    sts.out_busy  = out_valid;
  end

endmodule

// File: src/apsp_ctrl.sv
module apsp_ctrl
  import apsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  apsp_sts_t sts,
  output apsp_cmd_t cmd
);

  apsp_state_t state;
  apsp_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.edge_wr = 1'b1;
          state_next  = ST_EDGE2;
        end
      end
      ST_EDGE2: begin
        cmd.edge_rev = 1'b1;
        if (sts.edge_last) begin
          cmd.relax_start = 1'b1;
          state_next      = ST_IK_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_IK_RD: begin
        cmd.ik_rd  = 1'b1;
        state_next = ST_IK_WAIT;
      end
      ST_IK_WAIT: begin
        cmd.ik_load = 1'b1;
        if (sts.ik_valid) begin
          state_next = ST_ROW;
        end else begin
          cmd.step_ik = 1'b1;
          state_next  = (sts.i_last && sts.k_last) ? ST_FIN_RD : ST_IK_RD;
        end
      end
      ST_ROW: begin
        cmd.row_rd = 1'b1;
        if (sts.j_last) begin
          cmd.step_ik = 1'b1;
          state_next  = (sts.i_last && sts.k_last) ? ST_FIN_RD : ST_IK_RD;
        end
      end
      ST_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_next = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        cmd.fin_rd = 1'b1;
        if (!sts.out_busy) begin
          cmd.fin_load = 1'b1;
          state_next   = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: src/all_pairs_shortest_path.sv
// channel   direction  payload                                        handshake
// edges     in         from_node, to_node, edge_cost, last_edge       valid / ready
// result    out        distance, reachable                            valid / ready
// cfg       in         cfg_data (node_count)                          cfg_we
//
// an edge item takes one write per direction of the single ram write port, the reverse one after the forward one
// the last edge starts relaxation: for each (k, i) pair d[i][k] is read first, and
// when it is reachable j sweeps the n row elements (one row element read, add and write back per cycle)
// after each result, and after reset, the matrix is cleared one entry a cycle over all
// 2**(2*NODE_BITS) entries (16384), during which no edge item is taken
// a result waits in an output register; the final load stalls only if the previous one is untaken
module all_pairs_shortest_path
  import apsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  apsp_edge_if.sink             edges,
  apsp_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [FIELD_BITS-1:0] cfg_data
);

  apsp_cmd_t cmd;
  apsp_sts_t sts;

  // sequencer
  apsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edges.valid),
    .in_ready (edges.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // matrix, counters and adder
  apsp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .from_node (edges.from_node),
    .to_node   (edges.to_node),
    .edge_cost (edges.edge_cost),
    .last_edge (edges.last_edge),
    .distance  (result.distance),
    .reachable (result.reachable),
    .out_valid (result.valid),
    .out_ready (result.ready)
  );

endmodule

// File: src/apsp_checker.sv
module apsp_checker
  import apsp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DIST_BITS-1:0] out_distance,
  input logic                 out_reachable
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_reachable))
    else $error("result payload changed while stalled");

  // an unreachable destination reports zero distance
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reachable |-> out_distance == '0)
    else $error("unreachable result with nonzero distance");

  // the final edge is followed by a busy period
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready)
    else $error("edge taken right after the final edge");

  // a new result never appears while edges are being taken
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready && $past(!in_ready))
    else $error("result appeared during edge loading");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (edges.valid),
  .in_ready      (edges.ready),
  .in_last       (edges.last_edge),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_distance  (result.distance),
  .out_reachable (result.reachable)
);
